// ===== rtl/gtl_pkg.sv =====
// ----------------------------------------------------------------------------
// gtl_pkg: shared definitions for the glyph text layout block
// Glyph record, character codes, register indexes, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package gtl_pkg;

  localparam int MAX_CHARS_DEF = 64;
  localparam int GLYPHS        = 95;
  localparam int GIDX_W        = 7;
  localparam int CFG_IDX_W     = 3;

  localparam logic [7:0] CHAR_NUL   = 8'd0;
  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_FIRST = 8'd32;
  localparam logic [7:0] CHAR_LAST  = 8'd126;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOX_X,
    CFG_BOX_Y,
    CFG_BOX_W,
    CFG_BOX_H,
    CFG_H_ALIGN,
    CFG_V_ALIGN
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ALIGN_START,
    ALIGN_CENTER,
    ALIGN_END
  } align_t;

  typedef struct packed {
    logic [11:0] gx;
    logic [11:0] gy;
    logic [7:0]  gw;
    logic [7:0]  gh;
  } glyph_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SIZE,
    ST_OFFSET,
    ST_ORIGIN,
    ST_WALK_RD,
    ST_WALK_CHR,
    ST_WALK_GLY,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic load;
    logic size;
    logic offset;
    logic origin;
    logic rd_char;
    logic chr;
    logic place;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic item_mode;
    logic item_last;
    logic chr_nl;
    logic walk_end;
    logic count_zero;
    logic out_free;
  } sts_t;

  function automatic logic is_print(input logic [7:0] c);
    return (c >= CHAR_FIRST) && (c <= CHAR_LAST);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [15:0] usat16(input logic [16:0] v);
    return v[16] ? 16'hFFFF : v[15:0];
  endfunction

endpackage

// ===== rtl/gtl_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtl_ctrl: sequencing controller
// Accepts items, steps the load of one item and the alignment and walk of the
// buffered string when the final character arrives.
// ----------------------------------------------------------------------------
module gtl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  gtl_pkg::sts_t sts,
  output gtl_pkg::cmd_t cmd
);

  gtl_pkg::state_t state_r;
  gtl_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gtl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      gtl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = gtl_pkg::ST_LOAD;
        end
      end
      gtl_pkg::ST_LOAD: begin
        cmd.load = 1'b1;
        if (sts.item_mode && sts.item_last) begin
          state_nxt = gtl_pkg::ST_SIZE;
        end else begin
          state_nxt = gtl_pkg::ST_IDLE;
        end
      end
      gtl_pkg::ST_SIZE: begin
        cmd.size  = 1'b1;
        state_nxt = gtl_pkg::ST_OFFSET;
      end
      gtl_pkg::ST_OFFSET: begin
        cmd.offset = 1'b1;
        state_nxt  = gtl_pkg::ST_ORIGIN;
      end
      gtl_pkg::ST_ORIGIN: begin
        cmd.origin = 1'b1;
        state_nxt  = sts.count_zero ? gtl_pkg::ST_DONE : gtl_pkg::ST_WALK_RD;
      end
      gtl_pkg::ST_WALK_RD: begin
        cmd.rd_char = 1'b1;
        state_nxt   = gtl_pkg::ST_WALK_CHR;
      end
      gtl_pkg::ST_WALK_CHR: begin
        cmd.chr = 1'b1;
        if (sts.chr_nl) begin
          state_nxt = sts.walk_end ? gtl_pkg::ST_DONE : gtl_pkg::ST_WALK_RD;
        end else begin
          state_nxt = gtl_pkg::ST_WALK_GLY;
        end
      end
      gtl_pkg::ST_WALK_GLY: begin
        if (sts.out_free) begin
          cmd.place = 1'b1;
          state_nxt = sts.walk_end ? gtl_pkg::ST_DONE : gtl_pkg::ST_WALK_RD;
        end
      end
      gtl_pkg::ST_DONE: begin
        cmd.clear = 1'b1;
        state_nxt = gtl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gtl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/gtl_datapath.sv =====
// ----------------------------------------------------------------------------
// gtl_datapath: glyph table, string buffer, measurement and placement
// Holds the configuration, the glyph memory with valid bits, the character
// buffer, the line measurement and the cursor, and the result register.
// ----------------------------------------------------------------------------
module gtl_datapath #(
  parameter int MAX_CHARS = gtl_pkg::MAX_CHARS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gtl_pkg::cmd_t                   cmd,
  output gtl_pkg::sts_t                   sts,
  input  logic                            cfg_valid,
  input  logic [gtl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [11:0]                     cfg_data,
  input  logic                            in_mode,
  input  logic [7:0]                      in_char_code,
  input  logic                            in_last_char,
  input  logic [11:0]                     in_glyph_x,
  input  logic [11:0]                     in_glyph_y,
  input  logic [7:0]                      in_glyph_w,
  input  logic [7:0]                      in_glyph_h,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [15:0]              out_dest_x,
  output logic signed [15:0]              out_dest_y,
  output logic [11:0]                     out_src_x,
  output logic [11:0]                     out_src_y,
  output logic [7:0]                      out_width,
  output logic [7:0]                      out_height,
  output logic                            out_last_glyph
);

  localparam int CNT_W = $clog2(MAX_CHARS + 1);
  localparam int IDX_W = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  logic [11:0] box_x_r, box_y_r, box_w_r, box_h_r;
  logic [1:0]  h_align_r, v_align_r;

  logic           item_mode_r;
  logic [7:0]     item_code_r;
  logic           item_last_r;
  gtl_pkg::glyph_t item_g_r;

  gtl_pkg::glyph_t tbl_mem [gtl_pkg::GLYPHS];
  logic [gtl_pkg::GLYPHS-1:0] tbl_vld_r;
  gtl_pkg::glyph_t tbl_rd_r;
  logic            tbl_rd_vld_r;

  logic [6:0] buf_mem [MAX_CHARS];
  logic [6:0] buf_rd_r;

  logic [7:0]       tallest_r;
  logic [CNT_W-1:0] count_r, gcount_r, idx_r, placed_r;
  logic [15:0]      line_r, widest_r, height_r, tw_r, th_r;
  logic             ended_r;
  logic [18:0]      ax_r, ay_r;
  logic signed [15:0] sx_r, cur_x_r, cur_y_r;
  logic             out_valid_r;

  logic [7:0]       rd_diff;
  logic [7:0]       wr_diff;
  logic             rd_en;
  logic             def_wr;
  logic             ld_store;
  logic [7:0]       gw_ld;
  logic [15:0]      line_add, height_add;
  logic [18:0]      ax_nxt, ay_nxt, org_x, org_y, step_y, step_x;
  gtl_pkg::glyph_t  gly;
  logic             chr_print;

  assign chr_print = gtl_pkg::is_print({1'b0, buf_rd_r});
  assign rd_diff   = cmd.accept ? (in_char_code - gtl_pkg::CHAR_FIRST)
                                : ({1'b0, buf_rd_r} - gtl_pkg::CHAR_FIRST);
  assign rd_en     = (cmd.accept && gtl_pkg::is_print(in_char_code)) ||
                     (cmd.chr && chr_print);
  assign wr_diff   = item_code_r - gtl_pkg::CHAR_FIRST;
  assign def_wr    = cmd.load && !item_mode_r && gtl_pkg::is_print(item_code_r);
  assign ld_store  = !ended_r && (item_code_r != gtl_pkg::CHAR_NUL) &&
                     ((item_code_r == gtl_pkg::CHAR_NL) || gtl_pkg::is_print(item_code_r)) &&
                     (count_r < CNT_W'(MAX_CHARS));
  assign gw_ld      = tbl_rd_vld_r ? tbl_rd_r.gw : 8'd0;
  assign line_add   = gtl_pkg::usat16({1'b0, line_r} + {9'd0, gw_ld});
  assign height_add = gtl_pkg::usat16({1'b0, height_r} + {9'd0, tallest_r});
  assign gly        = tbl_rd_vld_r ? tbl_rd_r : '0;
  assign org_x      = ax_r + {7'd0, box_x_r};
  assign org_y      = ay_r + {7'd0, box_y_r};
  assign step_y     = {{3{cur_y_r[15]}}, cur_y_r} + {11'd0, tallest_r};
  assign step_x     = {{3{cur_x_r[15]}}, cur_x_r} + {11'd0, gly.gw};

  always_comb begin
    case (h_align_r)
      gtl_pkg::ALIGN_CENTER: ax_nxt = {8'd0, box_w_r[11:1]} - {4'd0, tw_r[15:1]};
      gtl_pkg::ALIGN_END:    ax_nxt = {7'd0, box_w_r} - {3'd0, tw_r};
      default:               ax_nxt = '0;
    endcase
    case (v_align_r)
      gtl_pkg::ALIGN_CENTER: ay_nxt = {8'd0, box_h_r[11:1]} - {4'd0, th_r[15:1]};
      gtl_pkg::ALIGN_END:    ay_nxt = {7'd0, box_h_r} - {3'd0, th_r};
      default:               ay_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_x_r   <= '0;
      box_y_r   <= '0;
      box_w_r   <= '0;
      box_h_r   <= '0;
      h_align_r <= '0;
      v_align_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        gtl_pkg::CFG_BOX_X:   box_x_r   <= cfg_data;
        gtl_pkg::CFG_BOX_Y:   box_y_r   <= cfg_data;
        gtl_pkg::CFG_BOX_W:   box_w_r   <= cfg_data;
        gtl_pkg::CFG_BOX_H:   box_h_r   <= cfg_data;
        gtl_pkg::CFG_H_ALIGN: h_align_r <= cfg_data[1:0];
        gtl_pkg::CFG_V_ALIGN: v_align_r <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_mode_r <= in_mode;
      item_code_r <= in_char_code;
      item_last_r <= in_last_char;
      item_g_r    <= '{gx: in_glyph_x, gy: in_glyph_y, gw: in_glyph_w, gh: in_glyph_h};
    end
  end

  always_ff @(posedge clk) begin
    if (def_wr) begin
      tbl_mem[wr_diff[gtl_pkg::GIDX_W-1:0]] <= item_g_r;
    end
    if (rd_en) begin
      tbl_rd_r     <= tbl_mem[rd_diff[gtl_pkg::GIDX_W-1:0]];
      tbl_rd_vld_r <= tbl_vld_r[rd_diff[gtl_pkg::GIDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && item_mode_r && ld_store) begin
      buf_mem[count_r[IDX_W-1:0]] <= item_code_r[6:0];
    end
    if (cmd.rd_char) begin
      buf_rd_r <= buf_mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.size) begin
      tw_r <= (line_r > widest_r) ? line_r : widest_r;
      th_r <= height_add;
    end
    if (cmd.offset) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_vld_r <= '0;
      tallest_r <= '0;
      count_r   <= '0;
      gcount_r  <= '0;
      line_r    <= '0;
      widest_r  <= '0;
      height_r  <= '0;
      ended_r   <= 1'b0;
      idx_r     <= '0;
      placed_r  <= '0;
      sx_r      <= '0;
      cur_x_r   <= '0;
      cur_y_r   <= '0;
    end else begin
      if (def_wr) begin
        tbl_vld_r[wr_diff[gtl_pkg::GIDX_W-1:0]] <= 1'b1;
        if (item_g_r.gh > tallest_r) begin
          tallest_r <= item_g_r.gh;
        end
      end
      if (cmd.load && item_mode_r && !ended_r) begin
        if (item_code_r == gtl_pkg::CHAR_NUL) begin
          ended_r <= 1'b1;
        end else if (ld_store) begin
          count_r <= count_r + CNT_W'(1);
          if (item_code_r == gtl_pkg::CHAR_NL) begin
            if (line_r > widest_r) begin
              widest_r <= line_r;
            end
            line_r   <= '0;
            height_r <= height_add;
          end else begin
            line_r   <= line_add;
            gcount_r <= gcount_r + CNT_W'(1);
          end
        end
      end
      if (cmd.origin) begin
        sx_r     <= gtl_pkg::sat16(org_x);
        cur_x_r  <= gtl_pkg::sat16(org_x);
        cur_y_r  <= gtl_pkg::sat16(org_y);
        idx_r    <= '0;
        placed_r <= '0;
      end
      if (cmd.chr && !chr_print) begin
        cur_y_r <= gtl_pkg::sat16(step_y);
        cur_x_r <= sx_r;
        idx_r   <= idx_r + CNT_W'(1);
      end
      if (cmd.place) begin
        cur_x_r  <= gtl_pkg::sat16(step_x);
        idx_r    <= idx_r + CNT_W'(1);
        placed_r <= placed_r + CNT_W'(1);
      end
      if (cmd.clear) begin
        count_r  <= '0;
        gcount_r <= '0;
        line_r   <= '0;
        widest_r <= '0;
        height_r <= '0;
        ended_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.place) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      out_dest_x     <= cur_x_r;
      out_dest_y     <= cur_y_r;
      out_src_x      <= gly.gx;
      out_src_y      <= gly.gy;
      out_width      <= gly.gw;
      out_height     <= gly.gh;
      out_last_glyph <= (placed_r + CNT_W'(1)) == gcount_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign sts.item_mode  = item_mode_r;
  assign sts.item_last  = item_last_r;
  assign sts.chr_nl     = !chr_print;
  assign sts.walk_end   = (idx_r + CNT_W'(1)) == count_r;
  assign sts.count_zero = count_r == '0;
  assign sts.out_free   = !out_valid_r || out_ready;

endmodule

// ===== rtl/glyph_text_layout.sv =====
// ----------------------------------------------------------------------------
// glyph_text_layout: text layout engine for a glyph atlas
// Every input request passes an accept state and a load state that reads the
// glyph memory and stores or measures it. A text request flagged as the final
// string character adds size, offset and origin alignment steps, then read,
// check and place steps per glyph, read and check steps per newline and a
// closing step, due to the registered reads of the single-port character
// buffer and glyph memory; placement waits while the result register is not
// taken. No request is taken during the walk; config writes are always taken.
// ----------------------------------------------------------------------------
module glyph_text_layout #(
  parameter int MAX_CHARS = gtl_pkg::MAX_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gtl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_last_char,
  input  logic [11:0]                   in_glyph_x,
  input  logic [11:0]                   in_glyph_y,
  input  logic [7:0]                    in_glyph_w,
  input  logic [7:0]                    in_glyph_h,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [15:0]            out_dest_x,
  output logic signed [15:0]            out_dest_y,
  output logic [11:0]                   out_src_x,
  output logic [11:0]                   out_src_y,
  output logic [7:0]                    out_width,
  output logic [7:0]                    out_height,
  output logic                          out_last_glyph
);

  gtl_pkg::cmd_t cmd;
  gtl_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  gtl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gtl_datapath #(
    .MAX_CHARS (MAX_CHARS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mode        (in_mode),
    .in_char_code   (in_char_code),
    .in_last_char   (in_last_char),
    .in_glyph_x     (in_glyph_x),
    .in_glyph_y     (in_glyph_y),
    .in_glyph_w     (in_glyph_w),
    .in_glyph_h     (in_glyph_h),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_dest_x     (out_dest_x),
    .out_dest_y     (out_dest_y),
    .out_src_x      (out_src_x),
    .out_src_y      (out_src_y),
    .out_width      (out_width),
    .out_height     (out_height),
    .out_last_glyph (out_last_glyph)
  );

endmodule

// ===== verif/glyph_layout_checker.sv =====
// ----------------------------------------------------------------------------
// glyph_layout_checker: scoreboard for the glyph text layout block
// Watches the configuration, character and placement channels. It keeps its
// own copy of the glyph atlas, the string buffer and the text measurements,
// predicts the placements for every accepted request, and compares each
// accepted placement with the oldest prediction. Mismatches, unexpected
// placements and the number of predictions still waiting go to the top.
// ----------------------------------------------------------------------------
module glyph_layout_checker #(
  parameter int MAX_CHARS = gtl_pkg::MAX_CHARS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [gtl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [11:0]                   cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_mode,
  input  logic [7:0]                    in_char_code,
  input  logic                          in_last_char,
  input  logic [11:0]                   in_glyph_x,
  input  logic [11:0]                   in_glyph_y,
  input  logic [7:0]                    in_glyph_w,
  input  logic [7:0]                    in_glyph_h,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [15:0]            out_dest_x,
  input  logic signed [15:0]            out_dest_y,
  input  logic [11:0]                   out_src_x,
  input  logic [11:0]                   out_src_y,
  input  logic [7:0]                    out_width,
  input  logic [7:0]                    out_height,
  input  logic                          out_last_glyph,
  output int                            errors,
  output int                            outstanding,
  output int                            placed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic MODE_GLYPH = 1'b0;

  typedef struct packed {
    logic signed [15:0] dest_x;
    logic signed [15:0] dest_y;
    logic [11:0]        src_x;
    logic [11:0]        src_y;
    logic [7:0]         width;
    logic [7:0]         height;
    logic               last_glyph;
  } placement_t;

  gtl_pkg::glyph_t atlas [gtl_pkg::GLYPHS];
  logic [7:0] tallest;
  logic [7:0] text_buf [MAX_CHARS];
  int         text_len;
  int         line_w;
  int         widest;
  int         text_h;
  logic       text_ended;
  logic [11:0] box_x, box_y, box_w, box_h;
  logic [1:0]  h_mode, v_mode;
  placement_t pending_placements [$];
  placement_t want, got;

  function automatic int clamp_s16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int cap_u16(input int v);
    return (v > 65535) ? 65535 : v;
  endfunction

  function automatic logic in_atlas(input logic [7:0] code);
    return (code >= gtl_pkg::CHAR_FIRST) && (code <= gtl_pkg::CHAR_LAST);
  endfunction

  task automatic flag_error(input string msg);
    if (errors < 10) $display("%t: %s", $realtime, msg);
    errors++;
  endtask

  task automatic place_text();
    int tw, th, ax, ay, sx, cx, cy, last_at;
    gtl_pkg::glyph_t g;
    placement_t spot;
    tw = (line_w > widest) ? line_w : widest;
    th = cap_u16(text_h + int'(tallest));
    ax = 0;
    ay = 0;
    if (h_mode == gtl_pkg::ALIGN_CENTER) ax = int'(box_w) / 2 - tw / 2;
    else if (h_mode == gtl_pkg::ALIGN_END) ax = int'(box_w) - tw;
    if (v_mode == gtl_pkg::ALIGN_CENTER) ay = int'(box_h) / 2 - th / 2;
    else if (v_mode == gtl_pkg::ALIGN_END) ay = int'(box_h) - th;
    sx = clamp_s16(int'(box_x) + ax);
    cx = sx;
    cy = clamp_s16(int'(box_y) + ay);
    last_at = -1;
    for (int i = 0; i < text_len; i++) begin
      if (text_buf[i] != gtl_pkg::CHAR_NL) last_at = i;
    end
    for (int i = 0; i < text_len; i++) begin
      if (text_buf[i] == gtl_pkg::CHAR_NL) begin
        cy = clamp_s16(cy + int'(tallest));
        cx = sx;
      end else begin
        g = atlas[text_buf[i] - gtl_pkg::CHAR_FIRST];
        spot.dest_x = cx[15:0];
        spot.dest_y = cy[15:0];
        spot.src_x = g.gx;
        spot.src_y = g.gy;
        spot.width = g.gw;
        spot.height = g.gh;
        spot.last_glyph = (i == last_at);
        pending_placements.push_back(spot);
        cx = clamp_s16(cx + int'(g.gw));
      end
    end
    text_len = 0;
    line_w = 0;
    widest = 0;
    text_h = 0;
    text_ended = 1'b0;
  endtask

  task automatic apply_request(input logic mode, input logic [7:0] code, input logic last,
                               input logic [11:0] gx, input logic [11:0] gy,
                               input logic [7:0] gw, input logic [7:0] gh);
    if (mode == MODE_GLYPH) begin
      if (in_atlas(code)) begin
        atlas[code - gtl_pkg::CHAR_FIRST] = {gx, gy, gw, gh};
        if (gh > tallest) tallest = gh;
      end
    end else begin
      if (!text_ended) begin
        if (code == gtl_pkg::CHAR_NUL) begin
          text_ended = 1'b1;
        end else if ((code == gtl_pkg::CHAR_NL || in_atlas(code)) &&
                     text_len < MAX_CHARS) begin
          text_buf[text_len] = code;
          text_len++;
          if (code == gtl_pkg::CHAR_NL) begin
            if (line_w > widest) widest = line_w;
            line_w = 0;
            text_h = cap_u16(text_h + int'(tallest));
          end else begin
            line_w = cap_u16(line_w + int'(atlas[code - gtl_pkg::CHAR_FIRST].gw));
          end
        end
      end
      if (last) place_text();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gtl_pkg::GLYPHS; i++) atlas[i] = '0;
      tallest = '0;
      text_len = 0;
      line_w = 0;
      widest = 0;
      text_h = 0;
      text_ended = 1'b0;
      box_x = '0;
      box_y = '0;
      box_w = '0;
      box_h = '0;
      h_mode = '0;
      v_mode = '0;
      pending_placements.delete();
      outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          gtl_pkg::CFG_BOX_X:   box_x = cfg_data;
          gtl_pkg::CFG_BOX_Y:   box_y = cfg_data;
          gtl_pkg::CFG_BOX_W:   box_w = cfg_data;
          gtl_pkg::CFG_BOX_H:   box_h = cfg_data;
          gtl_pkg::CFG_H_ALIGN: h_mode = cfg_data[1:0];
          gtl_pkg::CFG_V_ALIGN: v_mode = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        got = {out_dest_x, out_dest_y, out_src_x, out_src_y, out_width, out_height,
               out_last_glyph};
        if (pending_placements.size() == 0) begin
          flag_error($sformatf("unexpected placement dest (%0d,%0d) src (%0d,%0d)",
                               $signed(got.dest_x), $signed(got.dest_y), got.src_x,
                               got.src_y));
        end else begin
          want = pending_placements.pop_front();
          placed++;
          if (got.dest_x !== want.dest_x || got.dest_y !== want.dest_y ||
              got.src_x !== want.src_x || got.src_y !== want.src_y ||
              got.width !== want.width || got.height !== want.height ||
              got.last_glyph !== want.last_glyph) begin
            flag_error($sformatf({"placement %0d: expected dest (%0d,%0d) src (%0d,%0d) ",
                                  "%0dx%0d last %0b, got dest (%0d,%0d) src (%0d,%0d) ",
                                  "%0dx%0d last %0b"}, placed,
                                 $signed(want.dest_x), $signed(want.dest_y), want.src_x,
                                 want.src_y, want.width, want.height, want.last_glyph,
                                 $signed(got.dest_x), $signed(got.dest_y), got.src_x,
                                 got.src_y, got.width, got.height, got.last_glyph));
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_request(in_mode, in_char_code, in_last_char, in_glyph_x, in_glyph_y,
                      in_glyph_w, in_glyph_h);
      end
      outstanding = pending_placements.size();
    end
  end

endmodule

// ===== verif/glyph_text_layout_tb.sv =====
// ----------------------------------------------------------------------------
// glyph_text_layout_tb: top level test of the glyph text layout block
// Drives glyph definitions and strings through the block under a series of
// text box settings, with random gaps on both channels, a quiet stretch and
// one long output stall. A short directed part covers the edge cases; random
// strings follow. The checker beside the block predicts every placement.
// ----------------------------------------------------------------------------
module glyph_text_layout_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       MODE_GLYPH   = 1'b0;
  localparam logic       MODE_TEXT    = 1'b1;
  localparam logic [1:0] ALIGN_SPARE  = 2'd3;
  localparam int         ITEM_TARGET  = 410;
  localparam int         DRAIN_CYCLES = 160;
  localparam int         HOLD_CYCLES  = 300;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [gtl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [11:0]                   cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_mode = 1'b0;
  logic [7:0]                    in_char_code = '0;
  logic                          in_last_char = 1'b0;
  logic [11:0]                   in_glyph_x = '0;
  logic [11:0]                   in_glyph_y = '0;
  logic [7:0]                    in_glyph_w = '0;
  logic [7:0]                    in_glyph_h = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [15:0]            out_dest_x;
  logic signed [15:0]            out_dest_y;
  logic [11:0]                   out_src_x;
  logic [11:0]                   out_src_y;
  logic [7:0]                    out_width;
  logic [7:0]                    out_height;
  logic                          out_last_glyph;

  int errors;
  int outstanding;
  int placed;

  int n_items = 0;
  int n_defs = 0;
  int n_strings = 0;
  int n_settings = 0;
  bit calm = 1'b0;
  int hold_requests = 0;

  glyph_text_layout dut (.*);
  glyph_layout_checker chk (.*);

  always #10 clk = ~clk;

  task automatic send_req(input logic mode, input logic [7:0] code, input logic last,
                          input logic [11:0] gx, input logic [11:0] gy,
                          input logic [7:0] gw, input logic [7:0] gh);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_char_code <= code;
    in_last_char <= last;
    in_glyph_x <= gx;
    in_glyph_y <= gy;
    in_glyph_w <= gw;
    in_glyph_h <= gh;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    if (mode == MODE_GLYPH) n_defs++;
  endtask

  task automatic define_random_glyph();
    logic [7:0] code, gh;
    code = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                       : 8'($urandom_range(gtl_pkg::CHAR_FIRST,
                                                           gtl_pkg::CHAR_LAST));
    gh = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, 48));
    send_req(MODE_GLYPH, code, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
             12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)), gh);
  endtask

  task automatic send_text(input int len);
    int roll;
    logic [7:0] code;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 4) define_random_glyph();
      roll = $urandom_range(0, 99);
      if (roll < 76) code = 8'($urandom_range(gtl_pkg::CHAR_FIRST, gtl_pkg::CHAR_LAST));
      else if (roll < 88) code = gtl_pkg::CHAR_NL;
      else if (roll < 97) code = 8'($urandom_range(0, 255));
      else code = gtl_pkg::CHAR_NUL;
      send_req(MODE_TEXT, code, i == len - 1, 12'($urandom_range(0, 4095)),
               12'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
    end
    n_strings++;
  endtask

  task automatic write_reg(input gtl_pkg::cfg_reg_t idx, input logic [11:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [11:0] bx, input logic [11:0] by,
                           input logic [11:0] bw, input logic [11:0] bh,
                           input logic [1:0] ha, input logic [1:0] va);
    write_reg(gtl_pkg::CFG_BOX_X, bx);
    write_reg(gtl_pkg::CFG_BOX_Y, by);
    write_reg(gtl_pkg::CFG_BOX_W, bw);
    write_reg(gtl_pkg::CFG_BOX_H, bh);
    write_reg(gtl_pkg::CFG_H_ALIGN, {10'd0, ha});
    write_reg(gtl_pkg::CFG_V_ALIGN, {10'd0, va});
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [11:0] box_value(input int phase);
    int pick;
    if (phase == 1) return 12'hFFF;
    if (phase == 2) return 12'h000;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 12'h000;
    if (pick == 1) return 12'hFFF;
    return 12'($urandom_range(0, 4095));
  endfunction

  initial begin
    int holds_seen;
    holds_seen = 0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d placements still expected.", outstanding);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int phase, phase_start, roll, len;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    configure(12'h000, 12'hFFF, 12'hFFF, 12'h000, gtl_pkg::ALIGN_END, ALIGN_SPARE);
    send_req(MODE_GLYPH, gtl_pkg::CHAR_FIRST, 1'b1, 12'hFFF, 12'h000, 8'hFF, 8'd0);
    send_req(MODE_GLYPH, gtl_pkg::CHAR_LAST, 1'b0, 12'h000, 12'hFFF, 8'd0, 8'd16);
    send_req(MODE_GLYPH, "A", 1'b0, 12'd12, 12'd34, 8'd9, 8'd12);
    send_req(MODE_GLYPH, gtl_pkg::CHAR_FIRST - 8'd1, 1'b0, 12'd5, 12'd5, 8'd5, 8'd200);
    send_req(MODE_GLYPH, gtl_pkg::CHAR_LAST + 8'd1, 1'b0, 12'd7, 12'd7, 8'd7, 8'd250);
    send_req(MODE_GLYPH, 8'hFF, 1'b1, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF);
    send_req(MODE_TEXT, "A", 1'b0, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF);
    send_req(MODE_TEXT, gtl_pkg::CHAR_FIRST, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, gtl_pkg::CHAR_NL, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, gtl_pkg::CHAR_LAST, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, "B", 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, "A", 1'b1, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, gtl_pkg::CHAR_NL, 1'b1, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, "A", 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, 8'd7, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, 8'd200, 1'b1, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, "A", 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, gtl_pkg::CHAR_NUL, 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, "A", 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, "A", 1'b1, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_TEXT, "A", 1'b0, 12'd0, 12'd0, 8'd0, 8'd0);
    send_req(MODE_GLYPH, "A", 1'b0, 12'd100, 12'd200, 8'd30, 8'd20);
    send_req(MODE_TEXT, "A", 1'b1, 12'd0, 12'd0, 8'd0, 8'd0);
    n_strings += 5;
    settle();

    phase = 1;
    while (n_items < ITEM_TARGET) begin
      configure(box_value(phase), box_value(phase), box_value(phase), box_value(phase),
                2'(phase % 4), 2'($urandom_range(0, 3)));
      calm <= (phase == 3);
      phase_start = n_items;
      repeat ((phase == 1) ? 30 : $urandom_range(2, 6)) define_random_glyph();
      if (phase == 4) send_req(MODE_GLYPH, "W", 1'b0, 12'd64, 12'd64, 8'd24, 8'hFF);
      if (phase == 1) send_text(70);
      if (phase == 2) begin
        hold_requests <= hold_requests + 1;
        send_text($urandom_range(20, 40));
      end
      while (n_items - phase_start < 45 && n_items < ITEM_TARGET) begin
        roll = $urandom_range(0, 19);
        if (roll < 17) len = $urandom_range(1, 12);
        else if (roll < 19) len = $urandom_range(13, 40);
        else len = $urandom_range(60, 72);
        send_text(len);
      end
      settle();
      phase++;
    end

    $display("Ran %0d requests: %0d glyph definitions and %0d strings over %0d box settings.",
             n_items, n_defs, n_strings, n_settings);
    $display("Checked %0d placements: %0d errors, %0d never arrived.",
             placed, errors, outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== glyph_text_layout.f =====
rtl/gtl_pkg.sv
rtl/gtl_ctrl.sv
rtl/gtl_datapath.sv
rtl/glyph_text_layout.sv
verif/glyph_layout_checker.sv
verif/glyph_text_layout_tb.sv
